// ===== sv/uniform_histogram_fill_top_macros.svh =====
// Assertion macros for the histogram fill block.
// Used by the top level only; needs nothing else.
`ifndef UNIFORM_HISTOGRAM_FILL_TOP_MACROS_SVH
`define UNIFORM_HISTOGRAM_FILL_TOP_MACROS_SVH
`define UHF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define UHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== sv/uhf_pkg.sv =====
// Shared types and constants for the histogram fill block.
// No dependencies.
package uhf_pkg;
   localparam int NUM_BINS = 1024;
   localparam int ACCUM_BITS = 48;
   localparam int BIN_BITS = $clog2(NUM_BINS);
   localparam int ADDR_BITS = 11;
   localparam logic [2:0] CLS_IN = 3'd0;
   localparam logic [2:0] CLS_UNDER = 3'd1;
   localparam logic [2:0] CLS_OVER = 3'd2;
   localparam logic [2:0] CLS_INVAL = 3'd3;
   localparam logic [2:0] CLS_READ = 3'd4;
   localparam logic [2:0] REG_LOW = 3'd0;
   localparam logic [2:0] REG_HIGH = 3'd1;
   localparam logic [2:0] REG_WIDTH = 3'd2;
   localparam logic [2:0] REG_INV = 3'd3;
   localparam logic [2:0] REG_COUNT = 3'd4;
   localparam logic [2:0] REG_SQUARES = 3'd5;
   localparam logic [1:0] EV_IN = 2'd0;
   localparam logic [1:0] EV_UNDER = 2'd1;
   localparam logic [1:0] EV_OVER = 2'd2;
   localparam logic [1:0] EV_INVAL = 2'd3;

   typedef struct packed {
      logic                 is_read;
      logic [2:0]           cls;
      logic [BIN_BITS-1:0]  bin;
      logic [ADDR_BITS-1:0] addr;
      logic signed [15:0]   weight;
      logic                 last;
   } job_type;

   function automatic logic signed [ACCUM_BITS-1:0] sat_add_w(
      input logic signed [ACCUM_BITS-1:0] a, input logic signed [15:0] w);
      logic signed [ACCUM_BITS:0] s;
      s = {a[ACCUM_BITS-1], a} + {{(ACCUM_BITS-15){w[15]}}, w};
      if (s[ACCUM_BITS] != s[ACCUM_BITS-1])
         return s[ACCUM_BITS] ? {1'b1, {(ACCUM_BITS-1){1'b0}}}
                              : {1'b0, {(ACCUM_BITS-1){1'b1}}};
      return s[ACCUM_BITS-1:0];
   endfunction

   function automatic logic [ACCUM_BITS-1:0] sat_add_q(
      input logic [ACCUM_BITS-1:0] a, input logic [31:0] q);
      logic [ACCUM_BITS:0] s;
      s = {1'b0, a} + {{(ACCUM_BITS-31){1'b0}}, q};
      return s[ACCUM_BITS] ? {ACCUM_BITS{1'b1}} : s[ACCUM_BITS-1:0];
   endfunction
endpackage

// ===== sv/uhf_front.sv =====
// Front end: register inputs, classify, compute the bin in stages.
// Depends on uhf_pkg.
module uhf_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic                             op,
   input  logic signed [31:0]               value,
   input  logic signed [15:0]               weight,
   input  logic                             invalid,
   input  logic                             last,
   input  logic [uhf_pkg::ADDR_BITS-1:0]    addr,
   input  logic signed [31:0]               low,
   input  logic signed [31:0]               high,
   input  logic [30:0]                      width,
   input  logic [31:0]                      inv,
   input  logic [10:0]                      count,
   output logic                             out_valid,
   output uhf_pkg::job_type                 out_job
);
   // stage 1: classify, difference
   logic v1_ff;
   uhf_pkg::job_type j1_ff;
   logic [31:0] diff1_ff;
   logic signed [31:0] val1_ff;
   logic [10:0] nb1_ff;
   // stage 2: product
   logic v2_ff;
   uhf_pkg::job_type j2_ff;
   logic [63:0] prod2_ff;
   logic signed [31:0] val2_ff;
   logic [10:0] nb2_ff;
   // stage 3: edges
   logic v3_ff;
   uhf_pkg::job_type j3_ff;
   logic [10:0] idx3_ff;
   logic signed [31:0] val3_ff;
   logic [10:0] nb3_ff;
   logic signed [63:0] eup3_ff, edn3_ff;

   uhf_pkg::job_type j1_in, j4_in;
   logic [10:0] nb_in, idx_in, idx2, idx4;
   logic signed [32:0] d33;
   logic [41:0] up_prod, dn_prod;

   always_comb begin
      j1_in = '0;
      j1_in.is_read = op;
      j1_in.addr = addr;
      j1_in.weight = weight;
      j1_in.last = last;
      if (op) j1_in.cls = uhf_pkg::CLS_READ;
      else if (invalid) j1_in.cls = uhf_pkg::CLS_INVAL;
      else if (value < low) j1_in.cls = uhf_pkg::CLS_UNDER;
      else if (value >= high) j1_in.cls = uhf_pkg::CLS_OVER;
      else j1_in.cls = uhf_pkg::CLS_IN;
      d33 = {value[31], value} - {low[31], low};
      nb_in = count;
      if (nb_in == 11'd0) nb_in = 11'd1;
      if (nb_in > 11'(uhf_pkg::NUM_BINS)) nb_in = 11'(uhf_pkg::NUM_BINS);
      idx_in = (prod2_ff[63:32] > {21'd0, nb2_ff - 11'd1}) ? nb2_ff - 11'd1
               : prod2_ff[42:32];
      up_prod = 42'(idx_in + 11'd1) * 42'(width);
      dn_prod = 42'(idx_in) * 42'(width);
      idx2 = idx3_ff;
      if (idx2 + 11'd1 < nb3_ff && 64'(val3_ff) >= eup3_ff) idx2 = idx2 + 11'd1;
      idx4 = idx2;
      if (idx4 > 11'd0 && 64'(val3_ff) < ((idx2 == idx3_ff) ? edn3_ff : eup3_ff))
         idx4 = idx4 - 11'd1;
      j4_in = j3_ff;
      if (j3_ff.cls == uhf_pkg::CLS_IN) j4_in.bin = idx4[uhf_pkg::BIN_BITS-1:0];
      else j4_in.bin = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; out_valid <= 1'b0;
      end else begin
         v1_ff <= in_valid; v2_ff <= v1_ff; v3_ff <= v2_ff; out_valid <= v3_ff;
      end
      j1_ff <= j1_in; diff1_ff <= d33[31:0]; val1_ff <= value; nb1_ff <= nb_in;
      j2_ff <= j1_ff; prod2_ff <= {32'd0, diff1_ff} * {32'd0, inv};
      val2_ff <= val1_ff; nb2_ff <= nb1_ff;
      j3_ff <= j2_ff; idx3_ff <= idx_in; val3_ff <= val2_ff; nb3_ff <= nb2_ff;
      eup3_ff <= 64'(low) + 64'(up_prod);
      edn3_ff <= 64'(low) + 64'(dn_prod);
      out_job <= j4_in;
   end
endmodule

// ===== sv/uhf_queue.sv =====
// Short queue between front and back ends.
// Depends on uhf_pkg.
module uhf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  uhf_pkg::job_type push_job,
   input  logic             pop,
   output logic             not_empty,
   output uhf_pkg::job_type head
);
   uhf_pkg::job_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign not_empty = cnt_ff != 3'd0;
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wp_ff] <= push_job;
   end
endmodule

// ===== sv/uhf_back.sv =====
// Back end: bin memory read-modify-write, side sums, counts, result register.
// Depends on uhf_pkg.
module uhf_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 has_job,
   input  uhf_pkg::job_type                     job,
   input  logic                                 squares,
   output logic                                 pop,
   output logic                                 clearing,
   output logic                                 rsp_valid,
   output logic [2:0]                           rsp_result_class,
   output logic [9:0]                           rsp_bin_index,
   output logic signed [47:0]                   rsp_read_weight,
   output logic [47:0]                          rsp_read_square_sum,
   output logic [31:0]                          rsp_read_count,
   output logic                                 rsp_batch_invalid
);
   localparam int NB = uhf_pkg::NUM_BINS;
   localparam int BB = uhf_pkg::BIN_BITS;
   localparam int AB = uhf_pkg::ACCUM_BITS;
   localparam logic [1:0] ST_CLR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_RMW = 2'd2;

   logic signed [AB-1:0] wmem [NB];
   logic [AB-1:0] qmem [NB];
   logic signed [AB-1:0] wrd_ff;
   logic [AB-1:0] qrd_ff;
   logic [1:0] st_ff;
   logic [BB:0] clr_ff;
   uhf_pkg::job_type cur_ff;
   logic signed [AB-1:0] uw_ff, ow_ff, iw_ff;
   logic [AB-1:0] uq_ff, oq_ff, iq_ff;
   logic [31:0] ev_ff [4];
   logic seen_ff;
   logic signed [31:0] wext;
   logic [31:0] sq;
   logic wr_en;
   logic [BB-1:0] wr_addr;
   logic signed [AB-1:0] wr_w;
   logic [AB-1:0] wr_q;
   logic [9:0] rsp_bin_in;
   logic signed [47:0] rsp_w_in;
   logic [47:0] rsp_q_in;
   logic [31:0] rsp_cnt_in;
   logic rsp_binv_in;

   assign clearing = st_ff == ST_CLR;
   assign pop = st_ff == ST_IDLE && has_job;
   assign wext = 32'($signed(cur_ff.weight));
   assign sq = 32'(wext * wext);

   always_comb begin
      wr_en = 1'b0; wr_addr = cur_ff.bin; wr_w = wrd_ff; wr_q = qrd_ff;
      case (st_ff)
         ST_CLR: begin
            wr_en = 1'b1; wr_addr = clr_ff[BB-1:0]; wr_w = '0; wr_q = '0;
         end
         ST_RMW: begin
            if (!cur_ff.is_read && cur_ff.cls == uhf_pkg::CLS_IN) begin
               wr_en = 1'b1;
               wr_w = uhf_pkg::sat_add_w(wrd_ff, cur_ff.weight);
               if (squares) wr_q = uhf_pkg::sat_add_q(qrd_ff, sq);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_bin_in = cur_ff.bin; rsp_w_in = '0; rsp_q_in = '0; rsp_cnt_in = '0;
      rsp_binv_in = 1'b0;
      if (cur_ff.is_read) begin
         if (cur_ff.addr < 11'(NB)) begin
            rsp_bin_in = cur_ff.addr[9:0];
            rsp_w_in = wrd_ff; rsp_q_in = qrd_ff;
         end else if (cur_ff.addr == 11'(NB)) begin
            rsp_w_in = uw_ff; rsp_q_in = uq_ff;
            rsp_cnt_in = ev_ff[uhf_pkg::EV_UNDER];
         end else if (cur_ff.addr == 11'(NB + 1)) begin
            rsp_w_in = ow_ff; rsp_q_in = oq_ff;
            rsp_cnt_in = ev_ff[uhf_pkg::EV_OVER];
         end else if (cur_ff.addr == 11'(NB + 2)) begin
            rsp_w_in = iw_ff; rsp_q_in = iq_ff;
            rsp_cnt_in = ev_ff[uhf_pkg::EV_IN];
         end else if (cur_ff.addr == 11'(NB + 3)) begin
            rsp_cnt_in = ev_ff[uhf_pkg::EV_INVAL];
         end
      end else if (cur_ff.last) begin
         rsp_binv_in = seen_ff || cur_ff.cls == uhf_pkg::CLS_INVAL;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wmem[wr_addr] <= wr_w; qmem[wr_addr] <= wr_q;
      end
      if (pop) begin
         wrd_ff <= wmem[job.is_read ? job.addr[BB-1:0] : job.bin];
         qrd_ff <= qmem[job.is_read ? job.addr[BB-1:0] : job.bin];
         cur_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR; clr_ff <= '0; rsp_valid <= 1'b0; seen_ff <= 1'b0;
         uw_ff <= '0; ow_ff <= '0; iw_ff <= '0; uq_ff <= '0; oq_ff <= '0; iq_ff <= '0;
         for (int i = 0; i < 4; i++) ev_ff[i] <= '0;
      end else begin
         rsp_valid <= 1'b0;
         case (st_ff)
            ST_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (BB+1)'(NB - 1)) st_ff <= ST_IDLE;
            end
            ST_IDLE: if (pop) st_ff <= ST_RMW;
            ST_RMW: begin
               st_ff <= ST_IDLE;
               rsp_valid <= 1'b1;
               rsp_result_class <= cur_ff.cls;
               rsp_bin_index <= rsp_bin_in;
               rsp_read_weight <= rsp_w_in;
               rsp_read_square_sum <= rsp_q_in;
               rsp_read_count <= rsp_cnt_in;
               rsp_batch_invalid <= rsp_binv_in;
               if (!cur_ff.is_read) begin
                  case (cur_ff.cls)
                     uhf_pkg::CLS_INVAL: begin
                        if (ev_ff[uhf_pkg::EV_INVAL] != '1)
                           ev_ff[uhf_pkg::EV_INVAL] <= ev_ff[uhf_pkg::EV_INVAL] + 32'd1;
                     end
                     uhf_pkg::CLS_UNDER: begin
                        uw_ff <= uhf_pkg::sat_add_w(uw_ff, cur_ff.weight);
                        if (squares) uq_ff <= uhf_pkg::sat_add_q(uq_ff, sq);
                        if (ev_ff[uhf_pkg::EV_UNDER] != '1)
                           ev_ff[uhf_pkg::EV_UNDER] <= ev_ff[uhf_pkg::EV_UNDER] + 32'd1;
                     end
                     uhf_pkg::CLS_OVER: begin
                        ow_ff <= uhf_pkg::sat_add_w(ow_ff, cur_ff.weight);
                        if (squares) oq_ff <= uhf_pkg::sat_add_q(oq_ff, sq);
                        if (ev_ff[uhf_pkg::EV_OVER] != '1)
                           ev_ff[uhf_pkg::EV_OVER] <= ev_ff[uhf_pkg::EV_OVER] + 32'd1;
                     end
                     default: begin
                        iw_ff <= uhf_pkg::sat_add_w(iw_ff, cur_ff.weight);
                        if (squares) iq_ff <= uhf_pkg::sat_add_q(iq_ff, sq);
                        if (ev_ff[uhf_pkg::EV_IN] != '1)
                           ev_ff[uhf_pkg::EV_IN] <= ev_ff[uhf_pkg::EV_IN] + 32'd1;
                     end
                  endcase
                  if (cur_ff.last) seen_ff <= 1'b0;
                  else if (cur_ff.cls == uhf_pkg::CLS_INVAL) seen_ff <= 1'b1;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== sv/uniform_histogram_fill_top.sv =====
// Top level of the uniform-bin weighted histogram.
// Depends on uhf_pkg, uhf_front, uhf_queue, uhf_back and the macros header.
//
// Usage: pulse start with a request while busy is low; one result follows,
// shown for one cycle with rsp_valid. The receiver cannot stall.
// Fill (operation 0) classifies a sample and adds its weight to a bin or a
// side sum, or only counts it if invalid; read (operation 1) returns a bin
// or a side total. Path: 4 front stages, one queue write, then the back
// end's memory read and update, after which rsp_valid is registered. busy
// stays high from the accepting edge until the result is shown, so one item
// is in flight.
// Reset: synchronous, clears all sums and counts; a clearing pass then zeros
// all 1024 bin memory entries with busy high. Configuration writes go on the
// csr_ port at any time the block is idle.
`include "uniform_histogram_fill_top_macros.svh"
module uniform_histogram_fill_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [15:0] req_sample_weight,
   input  logic               req_sample_invalid,
   input  logic               req_last_of_batch,
   input  logic [10:0]        req_read_address,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   output logic [2:0]         rsp_result_class,
   output logic [9:0]         rsp_bin_index,
   output logic signed [47:0] rsp_read_weight,
   output logic [47:0]        rsp_read_square_sum,
   output logic [31:0]        rsp_read_count,
   output logic               rsp_batch_invalid
);
   logic signed [31:0] low_ff, high_ff;
   logic [30:0] width_ff;
   logic [31:0] inv_ff;
   logic [10:0] count_ff;
   logic sq_ff;
   logic accept, f_valid, q_ne, pop, clearing;
   uhf_pkg::job_type f_job, q_head;
   logic [2:0] inflight_ff, inflight_in;
   logic pend_ff;

   assign accept = start && !busy;
   // items in front pipe plus queue; queue holds 4
   assign inflight_in = inflight_ff + 3'(accept) - 3'(pop);
   assign busy = clearing || inflight_ff >= 3'd1 || pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff <= '0; high_ff <= 32'sd1024; width_ff <= 31'd1;
         inv_ff <= '1; count_ff <= 11'd1024; sq_ff <= 1'b0;
         inflight_ff <= '0; pend_ff <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         pend_ff <= pop;
         if (csr_write) begin
            case (csr_index)
               uhf_pkg::REG_LOW: low_ff <= csr_data;
               uhf_pkg::REG_HIGH: high_ff <= csr_data;
               uhf_pkg::REG_WIDTH: width_ff <= csr_data[30:0];
               uhf_pkg::REG_INV: inv_ff <= csr_data;
               uhf_pkg::REG_COUNT: count_ff <= csr_data[10:0];
               uhf_pkg::REG_SQUARES: sq_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   uhf_front u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .op(req_operation),
      .value(req_sample_value), .weight(req_sample_weight),
      .invalid(req_sample_invalid), .last(req_last_of_batch),
      .addr(req_read_address), .low(low_ff), .high(high_ff), .width(width_ff),
      .inv(inv_ff), .count(count_ff), .out_valid(f_valid), .out_job(f_job)
   );

   uhf_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_job(f_job),
      .pop(pop), .not_empty(q_ne), .head(q_head)
   );

   uhf_back u_back (
      .clock(clock), .reset(reset), .has_job(q_ne), .job(q_head),
      .squares(sq_ff), .pop(pop), .clearing(clearing), .rsp_valid(rsp_valid),
      .rsp_result_class(rsp_result_class), .rsp_bin_index(rsp_bin_index),
      .rsp_read_weight(rsp_read_weight), .rsp_read_square_sum(rsp_read_square_sum),
      .rsp_read_count(rsp_read_count), .rsp_batch_invalid(rsp_batch_invalid)
   );

   `UHF_ASSERT_IMPL(a_no_accept_clear, clock, reset, clearing, busy, "accept during clear")
   `UHF_ASSERT_IMPL(a_pop_has, clock, reset, pop, q_ne, "pop from empty queue")
   `UHF_ASSERT_NEXT(a_rsp_after_pop, clock, reset, pop, !rsp_valid, "result too early")
endmodule

// ===== sim/uniform_histogram_fill_top_tb.sv =====
// Self-checking testbench for uniform_histogram_fill_top: directed rows, then random fills
// and reads over several bin layouts, each result checked against a built-in bin predictor.
// Depends on uhf_pkg and the uniform_histogram_fill_top RTL.
module uniform_histogram_fill_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint W_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint W_MIN = -64'sh0000_8000_0000_0000;
   localparam longint unsigned Q_MAX = 64'h0000_FFFF_FFFF_FFFF;

   typedef struct {
      logic [2:0]         cls;
      logic [9:0]         bin;
      logic signed [47:0] weight;
      logic [47:0]        squares;
      logic [31:0]        count;
      logic               binv;
   } hist_result_type;

   typedef struct {
      logic               op;
      logic signed [31:0] value;
      logic signed [15:0] weight;
      logic               inval;
      logic               last;
      logic [10:0]        addr;
      logic               typed;
      logic [2:0]         cls;
      logic [9:0]         bin;
   } hist_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_operation;
   logic signed [31:0] req_sample_value;
   logic signed [15:0] req_sample_weight;
   logic               req_sample_invalid;
   logic               req_last_of_batch;
   logic [10:0]        req_read_address;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;
   logic               rsp_valid;
   logic [2:0]         rsp_result_class;
   logic [9:0]         rsp_bin_index;
   logic signed [47:0] rsp_read_weight;
   logic [47:0]        rsp_read_square_sum;
   logic [31:0]        rsp_read_count;
   logic               rsp_batch_invalid;

   uniform_histogram_fill_top uut (.*);

   // predictor state
   longint             cfg_low, cfg_high;
   longint unsigned    cfg_width, cfg_inv, cfg_count;
   logic               cfg_squares;
   logic signed [47:0] bin_weight [uhf_pkg::NUM_BINS];
   logic [47:0]        bin_square [uhf_pkg::NUM_BINS];
   logic signed [47:0] under_w, over_w, inrange_w;
   logic [47:0]        under_q, over_q, inrange_q;
   logic [31:0]        fills [4];
   logic               batch_bad;

   hist_result_type    expected_q[$];
   int                 mismatches;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic signed [47:0] add_weight(logic signed [47:0] a,
                                                     logic signed [15:0] w);
      longint s;
      s = longint'(a) + longint'(w);
      if (s > W_MAX) s = W_MAX;
      if (s < W_MIN) s = W_MIN;
      return s[47:0];
   endfunction

   function automatic logic [47:0] add_square(logic [47:0] a, longint unsigned q);
      longint unsigned s;
      s = {16'd0, a} + q;
      return (s > Q_MAX) ? Q_MAX[47:0] : s[47:0];
   endfunction

   function automatic void count_fill(logic [1:0] k);
      if (fills[k] != 32'hFFFF_FFFF) fills[k] = fills[k] + 32'd1;
   endfunction

   function automatic hist_result_type fill_histogram(logic op, logic signed [31:0] value,
         logic signed [15:0] weight, logic inval, logic last, logic [10:0] addr);
      hist_result_type r;
      longint          v;
      longint unsigned sq, diff, idx, nb;
      r = '{cls: uhf_pkg::CLS_IN, bin: '0, weight: '0, squares: '0, count: '0, binv: 1'b0};
      v = value;
      sq = longint'(weight) * longint'(weight);
      if (op) begin
         r.cls = uhf_pkg::CLS_READ;
         if (addr < uhf_pkg::NUM_BINS) begin
            r.bin = addr[9:0];
            r.weight = bin_weight[addr[uhf_pkg::BIN_BITS-1:0]];
            r.squares = bin_square[addr[uhf_pkg::BIN_BITS-1:0]];
         end else if (addr == uhf_pkg::NUM_BINS) begin
            r.weight = under_w; r.squares = under_q; r.count = fills[uhf_pkg::EV_UNDER];
         end else if (addr == uhf_pkg::NUM_BINS + 1) begin
            r.weight = over_w; r.squares = over_q; r.count = fills[uhf_pkg::EV_OVER];
         end else if (addr == uhf_pkg::NUM_BINS + 2) begin
            r.weight = inrange_w; r.squares = inrange_q; r.count = fills[uhf_pkg::EV_IN];
         end else if (addr == uhf_pkg::NUM_BINS + 3) begin
            r.count = fills[uhf_pkg::EV_INVAL];
         end
         return r;
      end
      if (inval) begin
         r.cls = uhf_pkg::CLS_INVAL;
         count_fill(uhf_pkg::EV_INVAL);
         batch_bad = 1'b1;
      end else if (v < cfg_low) begin
         r.cls = uhf_pkg::CLS_UNDER;
         under_w = add_weight(under_w, weight);
         if (cfg_squares) under_q = add_square(under_q, sq);
         count_fill(uhf_pkg::EV_UNDER);
      end else if (v >= cfg_high) begin
         r.cls = uhf_pkg::CLS_OVER;
         over_w = add_weight(over_w, weight);
         if (cfg_squares) over_q = add_square(over_q, sq);
         count_fill(uhf_pkg::EV_OVER);
      end else begin
         nb = cfg_count;
         if (nb < 1) nb = 1;
         if (nb > uhf_pkg::NUM_BINS) nb = uhf_pkg::NUM_BINS;
         diff = v - cfg_low;
         idx = (diff * cfg_inv) >> 32;
         if (idx > nb - 1) idx = nb - 1;
         if (idx + 1 < nb && v >= cfg_low + longint'((idx + 1) * cfg_width)) idx++;
         if (idx > 0 && v < cfg_low + longint'(idx * cfg_width)) idx--;
         r.bin = idx[9:0];
         bin_weight[idx[uhf_pkg::BIN_BITS-1:0]] =
            add_weight(bin_weight[idx[uhf_pkg::BIN_BITS-1:0]], weight);
         inrange_w = add_weight(inrange_w, weight);
         if (cfg_squares) begin
            bin_square[idx[uhf_pkg::BIN_BITS-1:0]] =
               add_square(bin_square[idx[uhf_pkg::BIN_BITS-1:0]], sq);
            inrange_q = add_square(inrange_q, sq);
         end
         count_fill(uhf_pkg::EV_IN);
      end
      if (last) begin
         r.binv = batch_bad;
         batch_bad = 1'b0;
      end
      return r;
   endfunction

   task automatic send(hist_row_type row);
      hist_result_type r;
      start <= 1'b1;
      req_operation <= row.op;
      req_sample_value <= row.value;
      req_sample_weight <= row.weight;
      req_sample_invalid <= row.inval;
      req_last_of_batch <= row.last;
      req_read_address <= row.addr;
      do @(posedge clock); while (busy);
      r = fill_histogram(row.op, row.value, row.weight, row.inval, row.last, row.addr);
      if (row.typed) begin
         r.cls = row.cls;
         r.bin = row.bin;
      end
      expected_q.push_back(r);
   endtask

   task automatic idle_gap();
      int g;
      g = $urandom_range(0, 99);
      if (g < 40) return;
      start <= 1'b0;
      if (g < 95) g = $urandom_range(1, 3);
      else g = $urandom_range(10, 60);
      repeat (g) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      case (index)
         uhf_pkg::REG_LOW:     cfg_low = longint'(signed'(data));
         uhf_pkg::REG_HIGH:    cfg_high = longint'(signed'(data));
         uhf_pkg::REG_WIDTH:   cfg_width = 64'(data[30:0]);
         uhf_pkg::REG_INV:     cfg_inv = 64'(data);
         uhf_pkg::REG_COUNT:   cfg_count = 64'(data[10:0]);
         uhf_pkg::REG_SQUARES: cfg_squares = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(int phase);
      logic [31:0]     lo, hi, wd, inv, cnt;
      longint unsigned q;
      wd = $urandom_range(1, 1000);
      cnt = $urandom_range(1, uhf_pkg::NUM_BINS);
      lo = $urandom_range(0, 200000) - 100000;
      hi = lo + wd * cnt + $urandom_range(0, 3) - 1;
      q = 64'h1_0000_0000 / wd;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      inv = q[31:0] - $urandom_range(0, 1);
      case (phase)
         1: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; wd = 32'hFFFF_FFFF;
                  inv = 32'd2; cnt = 32'd2; end
         2: inv = 32'd0;
         3: cnt = 32'd0;
         4: cnt = 32'hFFFF_FFFF;
         5: wd = 32'h8000_0000;
         6: begin wd = 32'd1; inv = 32'hFFFF_FFFF; cnt = uhf_pkg::NUM_BINS; end
         7: cnt = 32'd1;
         default: ;
      endcase
      drain();
      write_reg(uhf_pkg::REG_LOW, lo);
      write_reg(uhf_pkg::REG_HIGH, hi);
      write_reg(uhf_pkg::REG_WIDTH, wd);
      write_reg(uhf_pkg::REG_INV, inv);
      write_reg(uhf_pkg::REG_COUNT, cnt);
      write_reg(uhf_pkg::REG_SQUARES, (phase % 3 == 0) ? 32'hFFFF_FFFF : $urandom);
      csr_write <= 1'b0;
   endtask

   function automatic hist_row_type random_row();
      hist_row_type    row;
      int              m;
      longint          span, v;
      longint unsigned r64;
      row = '{default: '0};
      row.op = ($urandom_range(0, 4) == 0);
      m = $urandom_range(0, 9);
      if (m < 5) row.addr = 11'($urandom_range(0, uhf_pkg::NUM_BINS - 1));
      else if (m < 9) row.addr = 11'($urandom_range(uhf_pkg::NUM_BINS, uhf_pkg::NUM_BINS + 3));
      else row.addr = 11'($urandom);
      span = cfg_high - cfg_low;
      r64 = {$urandom, $urandom};
      m = $urandom_range(0, 9);
      if (m < 6 && span > 0) v = cfg_low + longint'(r64 % span);
      else if (m < 8) v = cfg_low + longint'(cfg_width * $urandom_range(0, 1025))
                          + $urandom_range(0, 2) - 1;
      else if (m < 9) v = cfg_high + $urandom_range(0, 3) - 2;
      else v = longint'(signed'($urandom));
      row.value = v[31:0];
      m = $urandom_range(0, 9);
      if (m < 3) row.weight = 16'sd1;
      else if (m < 7) row.weight = 16'($urandom_range(0, 40) - 20);
      else row.weight = 16'($urandom);
      row.inval = ($urandom_range(0, 19) == 0);
      row.last = ($urandom_range(0, 9) == 0);
      return row;
   endfunction

   always @(posedge clock) begin
      hist_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result class %0d", rsp_result_class);
         end else begin
            e = expected_q.pop_front();
            if (rsp_result_class !== e.cls || rsp_bin_index !== e.bin
                || rsp_read_weight !== e.weight || rsp_read_square_sum !== e.squares
                || rsp_read_count !== e.count || rsp_batch_invalid !== e.binv) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp cls %0d bin %0d w %0d q %0d n %0d bi %0d / %s",
                           e.cls, e.bin, e.weight, e.squares, e.count, e.binv,
                           $sformatf("got %0d %0d %0d %0d %0d %0d",
                                     rsp_result_class, rsp_bin_index, rsp_read_weight,
                                     rsp_read_square_sum, rsp_read_count,
                                     rsp_batch_invalid));
            end
         end
      end
   end

   initial begin
      hist_row_type rows[$];
      int           n;
      reset = 1'b1;
      start = 1'b0;
      req_operation = 1'b0;
      req_sample_value = '0;
      req_sample_weight = '0;
      req_sample_invalid = 1'b0;
      req_last_of_batch = 1'b0;
      req_read_address = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatches = 0;
      cfg_low = 0; cfg_high = 1024; cfg_width = 1; cfg_inv = 64'hFFFF_FFFF;
      cfg_count = 1024; cfg_squares = 1'b0;
      foreach (bin_weight[i]) begin bin_weight[i] = '0; bin_square[i] = '0; end
      under_w = '0; over_w = '0; inrange_w = '0;
      under_q = '0; over_q = '0; inrange_q = '0;
      foreach (fills[i]) fills[i] = '0;
      batch_bad = 1'b0;

      rows = '{
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_READ, 10'd0},
         '{1'b0, 32'sd0, 16'sd1, 1'b0, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_IN, 10'd0},
         '{1'b0, 32'sd1023, 16'sh7FFF, 1'b0, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_IN, 10'd1023},
         '{1'b0, 32'sd512, 16'sh8000, 1'b0, 1'b0, 11'h7FF, 1'b1, uhf_pkg::CLS_IN, 10'd512},
         '{1'b0, -32'sd1, 16'sd5, 1'b0, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_UNDER, 10'd0},
         '{1'b0, 32'sh8000_0000, 16'sh8000, 1'b0, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_UNDER,
           10'd0},
         '{1'b0, 32'sd1024, 16'sd1, 1'b0, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_OVER, 10'd0},
         '{1'b0, 32'sh7FFF_FFFF, 16'sh7FFF, 1'b0, 1'b1, 11'd0, 1'b1, uhf_pkg::CLS_OVER,
           10'd0},
         '{1'b0, 32'sd7, 16'sd1, 1'b1, 1'b0, 11'd0, 1'b1, uhf_pkg::CLS_INVAL, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd1024, 1'b1, uhf_pkg::CLS_READ, 10'd0},
         '{1'b0, 32'sd3, 16'sd2, 1'b0, 1'b1, 11'd0, 1'b1, uhf_pkg::CLS_IN, 10'd3},
         '{1'b0, -32'sd9, 16'sd1, 1'b1, 1'b1, 11'd0, 1'b1, uhf_pkg::CLS_INVAL, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd1023, 1'b0, uhf_pkg::CLS_READ, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd1025, 1'b0, uhf_pkg::CLS_READ, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd1026, 1'b0, uhf_pkg::CLS_READ, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd1027, 1'b0, uhf_pkg::CLS_READ, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'h7FF, 1'b1, uhf_pkg::CLS_READ, 10'd0},
         '{1'b1, 32'sd0, 16'sd0, 1'b0, 1'b0, 11'd512, 1'b0, uhf_pkg::CLS_READ, 10'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send(rows[i]);
         idle_gap();
      end

      for (int phase = 0; phase < 13; phase++) begin
         configure(phase);
         n = (phase < 8) ? 80 : 120;
         repeat (n) begin
            send(random_row());
            idle_gap();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/uhf_pkg.sv
sv/uhf_front.sv
sv/uhf_queue.sv
sv/uhf_back.sv
sv/uniform_histogram_fill_top.sv
sim/uniform_histogram_fill_top_tb.sv
